// File: src/jke_pkg.sv
// ----------------------------------------------------------------------------
// jke_pkg: shared types and constants of the json key string extractor
// Result codes, register indexes, character constants and the record that
// carries all results of one text byte from the front part to the back part.
// ----------------------------------------------------------------------------
package jke_pkg;

   // key and match window sizes
   localparam int KEY_MAX   = 16;
   localparam int WIN_DEPTH = KEY_MAX + 3;
   localparam int WIN_IDX_W = $clog2(WIN_DEPTH + 1);
   localparam int KEY_VEC_W = KEY_MAX * 8;

   // register widths
   localparam int KEY_LEN_W = 5;
   localparam int CSR_DW    = 64;
   localparam int CSR_AW    = 2;

   // results of one byte
   localparam int MAX_RES   = 8;
   localparam int RES_CNT_W = $clog2(MAX_RES + 1);
   localparam int RES_IDX_W = $clog2(MAX_RES);

   // decoupling queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // register indexes
   typedef enum logic [CSR_AW-1:0] {
      CSR_KEY_LENGTH = 2'd0,
      CSR_KEY_LOW    = 2'd1,
      CSR_KEY_HIGH   = 2'd2
   } jke_csr_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_CLOSED   = 2'd1,
      KIND_CUT      = 2'd2,
      KIND_NOTFOUND = 2'd3
   } jke_kind_type;

   typedef struct packed {
      logic [7:0]   ch;
      jke_kind_type kind;
   } jke_res_type;

   // all results caused by one text byte
   typedef struct packed {
      jke_res_type [MAX_RES-1:0] res;
      logic [RES_CNT_W-1:0]      count;
   } jke_rec_type;

endpackage

// File: src/jke_front.sv
// ----------------------------------------------------------------------------
// jke_front: key search and string decode front part
// Takes one text byte per cycle while take is high, runs the key match window and the value
// decoder, and writes a record of the byte's results into the queue when it has any.
// ----------------------------------------------------------------------------
module jke_front import jke_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic [KEY_LEN_W-1:0] key_length,
   input  logic [CSR_DW-1:0]    key_chars_low,
   input  logic [CSR_DW-1:0]    key_chars_high,
   output logic                 push,
   output jke_rec_type          push_rec
);

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_WS,
      PH_VALUE,
      PH_ESC,
      PH_UHEX,
      PH_DONE
   } phase_type;

   localparam int LEN_CMP_W = (WIN_IDX_W > KEY_LEN_W) ? WIN_IDX_W : KEY_LEN_W;

   phase_type              phase_ff, phase_in;
   logic [WIN_IDX_W-1:0]   fill_ff, fill_in, fill_next;
   logic [2:0]             hex_count_ff, hex_count_in;
   logic [15:0]            hex_value_ff, hex_value_in;
   logic [3:0][7:0]        hex_bytes_ff, hex_bytes_in;
   logic [7:0]             win_ff [WIN_DEPTH];
   logic [7:0]             win_next [WIN_DEPTH];
   logic                   shift_en;
   logic                   win_match;
   logic [WIN_IDX_W-1:0]   len_clip, pat_len, pat_start;
   logic [KEY_VEC_W-1:0]   key_vec;
   logic [WIN_DEPTH-1:0]   pos_bad;
   logic                   hex_ok;
   logic [3:0]             hex_nib;
   jke_rec_type            rec;

   // append one result to a record
   function automatic jke_rec_type add_res(input jke_rec_type r, input jke_kind_type k,
                                           input logic [7:0] c);
      jke_rec_type upd;
      upd = r;
      if (r.count < RES_CNT_W'(MAX_RES)) begin
         upd.res[r.count[RES_IDX_W-1:0]].kind = k;
         upd.res[r.count[RES_IDX_W-1:0]].ch   = (k == KIND_CHAR) ? c : 8'h00;
         upd.count = r.count + 1'b1;
      end
      return upd;
   endfunction

   // backslash, u and the hex digits held so far
   function automatic jke_rec_type add_flush(input jke_rec_type r, input logic [2:0] cnt,
                                             input logic [3:0][7:0] digits);
      jke_rec_type upd;
      upd = add_res(r, KIND_CHAR, CH_BSLASH);
      upd = add_res(upd, KIND_CHAR, CH_LOW_U);
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < cnt) begin
            upd = add_res(upd, KIND_CHAR, digits[k]);
         end
      end
      return upd;
   endfunction

   // strict hex digit decode
   always_comb begin
      hex_ok  = 1'b1;
      hex_nib = 4'h0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_nib = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         hex_nib = in_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // key pattern geometry
   assign key_vec   = KEY_VEC_W'({key_chars_high, key_chars_low});
   assign len_clip  = (LEN_CMP_W'(key_length) > LEN_CMP_W'(KEY_MAX)) ?
                      WIN_IDX_W'(KEY_MAX) : WIN_IDX_W'(key_length);
   assign pat_len   = len_clip + WIN_IDX_W'(3);
   assign pat_start = WIN_IDX_W'(WIN_DEPTH) - pat_len;
   assign fill_next = (fill_ff == WIN_IDX_W'(WIN_DEPTH)) ? fill_ff : fill_ff + 1'b1;

   // window with the new byte shifted in, compared at every position from the pattern start
   for (genvar p = 0; p < WIN_DEPTH; p++) begin : g_pos
      logic [WIN_IDX_W-1:0] t_pos;
      logic [KEY_VEC_W-1:0] key_shift;
      logic [7:0]           want;

      if (p == WIN_DEPTH - 1) begin : g_tail
         assign win_next[p] = in_byte;
      end else begin : g_body
         assign win_next[p] = win_ff[p+1];
      end

      always_comb begin
         t_pos     = WIN_IDX_W'(p) - pat_start;
         key_shift = key_vec >> {t_pos - 1'b1, 3'b000};
         if (t_pos == '0 || t_pos == len_clip + 1'b1) begin
            want = CH_QUOTE;
         end else if (t_pos == len_clip + 2'd2) begin
            want = CH_COLON;
         end else begin
            want = key_shift[7:0];
         end
      end

      assign pos_bad[p] = (WIN_IDX_W'(p) >= pat_start) && (win_next[p] != want);
   end

   assign win_match = (fill_next >= pat_len) && !(|pos_bad);

   // per-byte decode
   always_comb begin
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      hex_count_in = hex_count_ff;
      hex_value_in = hex_value_ff;
      hex_bytes_in = hex_bytes_ff;
      shift_en     = 1'b0;
      rec          = '0;

      unique case (phase_ff)
         PH_SEARCH: begin
            shift_en = 1'b1;
            fill_in  = fill_next;
            if (win_match) begin
               phase_in = PH_WS;
            end
         end
         PH_WS: begin
            if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                in_byte == CH_CR || in_byte == CH_LF) begin
               phase_in = PH_WS;
            end else if (in_byte == CH_QUOTE) begin
               phase_in = PH_VALUE;
            end else begin
               rec      = add_res(rec, KIND_NOTFOUND, 8'h00);
               phase_in = PH_DONE;
            end
         end
         PH_VALUE: begin
            if (in_byte == CH_QUOTE) begin
               rec      = add_res(rec, KIND_CLOSED, 8'h00);
               phase_in = PH_DONE;
            end else if (in_byte == CH_BSLASH) begin
               phase_in = PH_ESC;
            end else begin
               rec = add_res(rec, KIND_CHAR, in_byte);
            end
         end
         PH_ESC: begin
            phase_in = PH_VALUE;
            unique case (in_byte)
               CH_LOW_N:  rec = add_res(rec, KIND_CHAR, CH_LF);
               CH_LOW_T:  rec = add_res(rec, KIND_CHAR, CH_TAB);
               CH_LOW_R:  rec = add_res(rec, KIND_CHAR, CH_CR);
               CH_LOW_B:  rec = add_res(rec, KIND_CHAR, CH_BS);
               CH_LOW_F:  rec = add_res(rec, KIND_CHAR, CH_FF);
               CH_QUOTE:  rec = add_res(rec, KIND_CHAR, CH_QUOTE);
               CH_BSLASH: rec = add_res(rec, KIND_CHAR, CH_BSLASH);
               CH_SLASH:  rec = add_res(rec, KIND_CHAR, CH_SLASH);
               CH_LOW_U: begin
                  phase_in     = PH_UHEX;
                  hex_count_in = 3'd0;
                  hex_value_in = 16'h0000;
               end
               default: begin
                  rec = add_res(rec, KIND_CHAR, CH_BSLASH);
                  rec = add_res(rec, KIND_CHAR, in_byte);
               end
            endcase
         end
         PH_UHEX: begin
            if (hex_ok && hex_count_ff < 3'd4) begin
               hex_bytes_in[hex_count_ff[1:0]] = in_byte;
               hex_value_in = {hex_value_ff[11:0], hex_nib};
               hex_count_in = hex_count_ff + 1'b1;
               if (hex_count_ff == 3'd3) begin
                  // fourth digit: decode, codes of 128 and up vanish
                  if (hex_value_in[15:7] == '0) begin
                     rec = add_res(rec, KIND_CHAR, hex_value_in[7:0]);
                  end
                  hex_count_in = 3'd0;
                  phase_in     = PH_VALUE;
               end
            end else begin
               // bad digit: escape goes out literally, byte is a fresh value byte
               rec          = add_flush(rec, hex_count_ff, hex_bytes_ff);
               hex_count_in = 3'd0;
               phase_in     = PH_VALUE;
               if (in_byte == CH_QUOTE) begin
                  rec      = add_res(rec, KIND_CLOSED, 8'h00);
                  phase_in = PH_DONE;
               end else if (in_byte == CH_BSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  rec = add_res(rec, KIND_CHAR, in_byte);
               end
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // end of message status and message state clear
      if (in_last) begin
         unique case (phase_in)
            PH_SEARCH, PH_WS: begin
               rec = add_res(rec, KIND_NOTFOUND, 8'h00);
            end
            PH_ESC: begin
               rec = add_res(rec, KIND_CHAR, CH_BSLASH);
               rec = add_res(rec, KIND_CUT, 8'h00);
            end
            PH_UHEX: begin
               rec = add_flush(rec, hex_count_in, hex_bytes_in);
               rec = add_res(rec, KIND_CUT, 8'h00);
            end
            PH_VALUE: begin
               rec = add_res(rec, KIND_CUT, 8'h00);
            end
            default: begin
               rec = rec;
            end
         endcase
         phase_in     = PH_SEARCH;
         fill_in      = '0;
         hex_count_in = 3'd0;
         hex_value_in = 16'h0000;
      end
   end

   assign push     = take && (rec.count != '0);
   assign push_rec = rec;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         fill_ff      <= '0;
         hex_count_ff <= 3'd0;
         hex_value_ff <= 16'h0000;
      end else if (take) begin
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         hex_count_ff <= hex_count_in;
         hex_value_ff <= hex_value_in;
      end
   end

   // window and hex digit payload
   always_ff @(posedge clock) begin
      if (take) begin
         hex_bytes_ff <= hex_bytes_in;
         if (shift_en) begin
            for (int p = 0; p < WIN_DEPTH; p++) begin
               win_ff[p] <= win_next[p];
            end
         end
      end
   end

   // a finished message leaves the front searching with no hex digits held
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      take && in_last |=> phase_ff == PH_SEARCH && hex_count_ff == 3'd0 && fill_ff == '0)
      else $error("message state not cleared after last byte");

   // hex digits are only held inside a unicode escape
   a_hex_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_UHEX |-> hex_count_ff == 3'd0)
      else $error("hex digits held outside unicode escape");

endmodule

// File: src/jke_queue.sv
// ----------------------------------------------------------------------------
// jke_queue: record queue between front and back parts
// Small register queue of per-byte result records; lets the front keep
// taking bytes while the back waits on the result channel.
// ----------------------------------------------------------------------------
module jke_queue import jke_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  jke_rec_type push_rec,
   input  logic        pop,
   output jke_rec_type head_rec,
   output logic        full,
   output logic        not_empty
);

   jke_rec_type         mem [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]  count_ff;
   logic                do_pop;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_rec  = mem[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // record storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   // the front never writes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !do_pop))
      else $error("record written into full queue");

endmodule

// File: src/jke_back.sv
// ----------------------------------------------------------------------------
// jke_back: result delivery back part
// Walks the head record of the queue and hands out one result item per
// cycle while rsp_stall is low, marking the last result of each text byte.
// ----------------------------------------------------------------------------
module jke_back import jke_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  jke_rec_type  head_rec,
   input  logic         head_valid,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_char,
   output logic [1:0]   rsp_out_kind,
   output logic         rsp_out_last
);

   logic [RES_IDX_W-1:0] idx_ff, idx_in;
   logic                 is_last;
   logic                 give;
   jke_res_type          cur;

   assign cur          = head_rec.res[idx_ff];
   assign is_last      = ({1'b0, idx_ff} + 1'b1) == head_rec.count;
   assign rsp_valid    = head_valid;
   assign rsp_out_char = cur.ch;
   assign rsp_out_kind = cur.kind;
   assign rsp_out_last = is_last;
   assign give         = rsp_valid && !rsp_stall;
   assign pop          = give && is_last;

   // next result position within the head record
   always_comb begin
      idx_in = idx_ff;
      if (give) begin
         idx_in = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // the walk never runs past the results of the head record
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, idx_ff} < head_rec.count))
      else $error("result index beyond record");

   // a record in the queue always carries at least one result
   a_rec_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> head_rec.count != '0)
      else $error("empty record in queue");

endmodule

// File: src/json_key_string_extractor.sv
// ----------------------------------------------------------------------------
// json_key_string_extractor: JSON key search and string value decoder
// Finds the configured key in a JSON byte stream and delivers its string
// value with escapes decoded, followed by one status per message.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req       in         req_valid/stall     req_in_byte, req_in_last
//  rsp       out        rsp_valid/stall     rsp_out_char, rsp_out_kind, rsp_out_last
//  csr       in         csr_we              csr_index, csr_data
//
//  One text byte is taken per cycle while the record queue has room; the
//  results of a byte appear on rsp in the cycle after it is taken at earliest.
//  The back part hands out one result per cycle while rsp_stall is low and
//  stays on a byte's record until each of its results is out; sustained rate
//  is one byte per cycle whenever bytes average at most one result each.
//  Reset is synchronous and clears message state, queue and the key registers.
//  rsp_stall holds the back part; up to four records wait in the queue
//  before req_stall rises.
// ----------------------------------------------------------------------------
module json_key_string_extractor import jke_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_in_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic [1:0]        rsp_out_kind,
   output logic              rsp_out_last,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [CSR_DW-1:0]    key_low_ff;
   logic [CSR_DW-1:0]    key_high_ff;
   logic                 take;
   logic                 push;
   jke_rec_type          push_rec;
   jke_rec_type          head_rec;
   logic                 q_full;
   logic                 q_not_empty;
   logic                 pop;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= '0;
         key_low_ff    <= '0;
         key_high_ff   <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_KEY_LENGTH) begin
            key_length_ff <= csr_data[KEY_LEN_W-1:0];
         end else if (csr_index == CSR_KEY_LOW) begin
            key_low_ff <= csr_data;
         end else if (csr_index == CSR_KEY_HIGH) begin
            key_high_ff <= csr_data;
         end
      end
   end

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   jke_front u_front (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .in_byte        (req_in_byte),
      .in_last        (req_in_last),
      .key_length     (key_length_ff),
      .key_chars_low  (key_low_ff),
      .key_chars_high (key_high_ff),
      .push           (push),
      .push_rec       (push_rec)
   );

   jke_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .head_rec  (head_rec),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   jke_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_rec     (head_rec),
      .head_valid   (q_not_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_last (rsp_out_last)
   );

endmodule
